[sv/cq_pkg.sv]
package cq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Port widths fixed by the interface
  localparam int CMD_PW  = 2;
  localparam int IDX_PW  = 4;
  localparam int DATA_PW = 32;
  localparam int STAT_PW = 2;
  localparam int CNT_PW  = 5;

  localparam logic [CMD_PW-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_PW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_PW-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STAT_PW-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_PW-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_PW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_PW-1:0]     cmd;
    logic [IDX_PW-1:0]     idx;
    logic [DATA_WIDTH-1:0] data;
  } cq_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [STAT_PW-1:0]    status;
    logic [CNT_W-1:0]      count;
  } cq_rsp_t;

endpackage

[sv/cq_in_reg.sv]
module cq_in_reg
  import cq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  cq_req_t req,
  output logic    req_vld,
  output cq_req_t req_q
);

  logic    vld_r, vld_nxt;
  cq_req_t req_r, req_nxt;

  assign vld_nxt = take;
  assign req_nxt = req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload: capture on accept only
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= req_nxt;
    end
  end

  assign req_vld = vld_r;
  assign req_q   = req_r;

endmodule

[sv/cq_core.sv]
module cq_core
  import cq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    req_vld,
  input  cq_req_t req,
  output logic    rsp_vld,
  output cq_rsp_t rsp
);

  logic [DATA_WIDTH-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  vld_r;
  cq_rsp_t               rsp_r, rsp_nxt;

  logic                  push_en, rm_en, in_range, full;
  logic [CNT_W-1:0]      pos_ext;
  logic [IDX_W-1:0]      pos, tail;

  assign full     = (cnt_r >= CNT_W'(DEPTH));
  assign pos_ext  = CNT_W'(req.idx);
  assign in_range = (pos_ext < cnt_r) && ({1'b0, req.idx} < (IDX_PW + 1)'(DEPTH));
  assign pos      = IDX_W'(req.idx);
  assign tail     = cnt_r[IDX_W-1:0];

  always_comb begin
    push_en     = 1'b0;
    rm_en       = 1'b0;
    cnt_nxt     = cnt_r;
    rsp_nxt     = '0;
    case (req.cmd)
      CMD_PUSH: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          push_en = req_vld;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (!in_range) begin
          rsp_nxt.status = ST_RANGE;
        end else begin
          rsp_nxt.data = entries_r[pos];
          if (req.cmd == CMD_REMOVE) begin
            rm_en   = req_vld;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    rsp_nxt.count = cnt_nxt;
  end

  // Collapse: slots from the removed one to DEPTH-2 take their upper neighbor
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (rm_en && (IDX_W'(k) >= pos) && (k + 1 < DEPTH)) begin
        entries_r[IDX_W'(k)] <= entries_r[IDX_W'(k + 1)];
      end else if (push_en && (IDX_W'(k) == tail)) begin
        entries_r[IDX_W'(k)] <= req.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= req_vld;
      if (req_vld) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp_vld = vld_r;
  assign rsp     = rsp_r;

endmodule

[sv/collapsing_queue_indexed_top.sv]
// A word accepted on start passes the request register, then the result register,
// on its way to the out_ ports. Throughput: one word per cycle; the queue update
// is a single pass through the collapse network between the two registers.
// busy stays low, and the receiver cannot stall: out_valid lasts one cycle.
// Reset (rst_n, synchronous, active low) empties the queue and clears strobes;
// the storage itself is not cleared.
module collapsing_queue_indexed_top
  import cq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_PW-1:0]  in_cmd,
  input  logic [IDX_PW-1:0]  in_index,
  input  logic [DATA_PW-1:0] in_data_in,
  output logic               out_valid,
  output logic [DATA_PW-1:0] out_data_out,
  output logic [STAT_PW-1:0] out_status,
  output logic [CNT_PW-1:0]  out_count
);

  cq_req_t req_in, req_q;
  cq_rsp_t rsp;
  logic    take, req_vld;

  // Every operation finishes in one pass, so never hold off the sender
  assign busy = 1'b0;
  assign take = start && !busy;

  // Mask the data word to the storage width
  assign req_in.cmd  = in_cmd;
  assign req_in.idx  = in_index;
  assign req_in.data = in_data_in[DATA_WIDTH-1:0];

  // Stage one: register the request word
  cq_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .req     (req_in),
    .req_vld (req_vld),
    .req_q   (req_q)
  );

  // Stage two: read, collapse or append, and register the result word
  cq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (req_vld),
    .req     (req_q),
    .rsp_vld (out_valid),
    .rsp     (rsp)
  );

  assign out_data_out = DATA_PW'(rsp.data);
  assign out_status   = rsp.status;
  assign out_count    = CNT_PW'(rsp.count);

endmodule

[verif/collapsing_queue_indexed_top_test.sv]
`timescale 1ns / 100ps

module collapsing_queue_indexed_top_test;
  import cq_pkg::*;

  // Spare command code: the block must treat it as a no-op.
  localparam logic [CMD_PW-1:0] CMD_NOP = 2'd3;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Pipeline depth from start to out_valid, plus margin.
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [DATA_PW-1:0] data;
    logic [STAT_PW-1:0] status;
    logic [CNT_PW-1:0]  count;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_PW-1:0]  in_cmd = CMD_PUSH;
  logic [IDX_PW-1:0]  in_index = '0;
  logic [DATA_PW-1:0] in_data_in = '0;
  logic               out_valid;
  logic [DATA_PW-1:0] out_data_out;
  logic [STAT_PW-1:0] out_status;
  logic [CNT_PW-1:0]  out_count;

  // Shadow of the queue contents, head at position 0.
  logic [DATA_PW-1:0] shadow_words[$];
  // Results predicted for accepted words, oldest first.
  queue_result_t      pending_results[$];

  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int full_drops = 0;
  int range_misses = 0;
  int removes_mid = 0;
  int stall_cycles = 0;
  int burst_left = 0;

  collapsing_queue_indexed_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_index     (in_index),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_count    (out_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the shadow queue and return the result the block
  // must produce for it.
  function automatic queue_result_t queue_apply(input logic [CMD_PW-1:0] cmd,
                                                input logic [IDX_PW-1:0] idx,
                                                input logic [DATA_PW-1:0] data);
    queue_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        // Drop the word when full; storage and count stay as they are.
        if (shadow_words.size() >= DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          shadow_words.push_back(data);
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (idx >= shadow_words.size()) begin
          r.status = ST_RANGE;
          range_misses++;
        end else begin
          r.data = shadow_words[idx];
          // Collapse: every later entry moves down by one place.
          if (cmd == CMD_REMOVE) begin
            if (idx != 0 && idx + 1 < shadow_words.size()) removes_mid++;
            shadow_words.delete(idx);
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_PW'(shadow_words.size());
    return r;
  endfunction

  // Send one word. The sender runs in bursts: when a burst is used up, drop
  // start for a random gap (sometimes none) and pick the next burst length.
  // Return right after the accepting edge with start still high.
  task automatic send_word(input logic [CMD_PW-1:0] cmd, input logic [IDX_PW-1:0] idx,
                           input logic [DATA_PW-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Mostly short bursts, now and then a long stretch with no idling.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 16);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_index   <= idx;
    in_data_in <= data;
    // Values read right after the edge are the ones the block sampled.
    do @(posedge clk); while (busy);
    pending_results.push_back(queue_apply(cmd, idx, data));
    words_sent++;
    burst_left--;
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Pick an index: mostly a live position, sometimes anything the field allows.
  function automatic logic [IDX_PW-1:0] pick_index();
    if (shadow_words.size() > 0 && $urandom_range(0, 9) < 8)
      return IDX_PW'($urandom_range(0, shadow_words.size() - 1));
    return IDX_PW'($urandom_range(0, (1 << IDX_PW) - 1));
  endfunction

  // Empty queue, fill to the brim, overflow, then reads and removes at the
  // head, the tail, the middle and past the end.
  task automatic test_directed_edges();
    int i;
    send_word(CMD_REMOVE, 4'd0, 32'h0);
    send_word(CMD_PEEK, 4'd15, 32'hFFFF_FFFF);
    send_word(CMD_NOP, 4'd15, 32'hFFFF_FFFF);
    send_word(CMD_PUSH, 4'd0, 32'h0000_0000);
    send_word(CMD_PUSH, 4'd15, 32'hFFFF_FFFF);
    send_word(CMD_PUSH, 4'd0, 32'h5555_5555);
    send_word(CMD_PUSH, 4'd0, 32'hAAAA_AAAA);
    for (i = 4; i < DEPTH; i++) send_word(CMD_PUSH, 4'd0, $urandom);
    send_word(CMD_PUSH, 4'd0, 32'hDEAD_BEEF);
    send_word(CMD_PEEK, 4'd15, 32'h0);
    send_word(CMD_PEEK, 4'd0, 32'h0);
    send_word(CMD_REMOVE, 4'd15, 32'h0);
    send_word(CMD_REMOVE, 4'd0, 32'h0);
    send_word(CMD_REMOVE, 4'd7, 32'h0);
    send_word(CMD_PEEK, 4'd13, 32'h0);
  endtask

  // Well-formed churn: epochs that lean toward pushes alternate with epochs
  // that lean toward removes, so the fill level sweeps between empty and full.
  task automatic test_random_churn(input int n_words);
    int sent;
    int epoch_left;
    int push_pct;
    logic [CMD_PW-1:0] cmd;
    sent       = 0;
    epoch_left = 0;
    push_pct   = 70;
    while (sent < n_words) begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 80);
        push_pct   = (push_pct > 50) ? 30 : 70;
      end
      if ($urandom_range(0, 99) < push_pct) cmd = CMD_PUSH;
      else cmd = ($urandom_range(0, 1) == 0) ? CMD_REMOVE : CMD_PEEK;
      send_word(cmd, pick_index(), $urandom);
      epoch_left--;
      sent++;
    end
  endtask

  // Noise: any command code including the spare one, any index.
  task automatic test_random_noise(input int n_words);
    int i;
    for (i = 0; i < n_words; i++)
      send_word(CMD_PW'($urandom_range(0, 3)), IDX_PW'($urandom_range(0, 15)), $urandom);
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%0d count=%0d",
                 $time, out_data_out, out_status, out_count);
        error_count++;
      end else begin
        automatic queue_result_t want = pending_results.pop_front();
        if (out_data_out !== want.data) begin
          $display("%0t: data mismatch, expected %h got %h", $time, want.data, out_data_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d",
                   $time, want.status, out_status);
          error_count++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count mismatch, expected %0d got %0d",
                   $time, want.count, out_count);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    drain_results();
    test_random_churn(1200);
    // Pause mid-run until the pipe is empty, then carry on.
    drain_results();
    test_random_noise(250);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d results: %0d full drops, %0d range misses,",
             words_sent, results_checked, full_drops, range_misses);
    $display("%0d mid-queue removes; %0d predictions left over.",
             removes_mid, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
